/* rtl/core/cpg_pkg.sv */
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

  // Symmetric points per octant step
  localparam int unsigned NUM_PTS = 8;

  // Decision variable constants of the midpoint circle algorithm
  localparam int D_INIT    = 3;   // d = 3 - 2r on load
  localparam int D_ADD_NEG = 6;   // d < 0  : d += 4x + 6
  localparam int D_ADD_POS = 10;  // d >= 0 : d += 4(x - y) + 10

  // Request kinds (tuser on the input side)
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } cpg_req_e;

  // Control for one burst of points, core -> emitter
  typedef struct packed {
    logic [NUM_PTS-1:0] mask;      // points still to send, bit i = octant point i
    logic               pt_valid;  // 0: single invalid result
    logic               done;      // circle complete after this step
  } cpg_burst_t;

endpackage

/* rtl/core/cpg_core.sv */
// ----------------------------------------------------------------------------
// cpg_core
// Circle state registers, decision update and duplicate-point mask.
// ----------------------------------------------------------------------------
module cpg_core #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          req_type_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          burst_load_o,
  output cpg_pkg::cpg_burst_t           burst_ctl_o,
  output logic signed [COORD_BITS-1:0]  ctr_x_o,
  output logic signed [COORD_BITS-1:0]  ctr_y_o,
  output logic        [RADIUS_BITS-1:0] pos_x_o,
  output logic        [RADIUS_BITS-1:0] pos_y_o
);

  localparam int unsigned DW = RADIUS_BITS + 4;  // decision width
  localparam int unsigned OW = RADIUS_BITS + 2;  // offset / compare width

  logic signed [COORD_BITS-1:0]  ctr_x_q, ctr_x_d;
  logic signed [COORD_BITS-1:0]  ctr_y_q, ctr_y_d;
  logic        [RADIUS_BITS:0]   step_x_q, step_x_d;
  logic signed [RADIUS_BITS:0]   step_y_q, step_y_d;
  logic signed [DW-1:0]          dec_q, dec_d;
  logic                          active_q, active_d;

  logic signed [OW-1:0] xs, ys, xn, yn;
  logic signed [DW-1:0] x_ext, y_ext;
  logic signed [OW-1:0] off_x [cpg_pkg::NUM_PTS];
  logic signed [OW-1:0] off_y [cpg_pkg::NUM_PTS];
  logic [cpg_pkg::NUM_PTS-1:0] keep;
  logic                 can_step;
  logic                 is_step;

  assign is_step  = (req_type_i == cpg_pkg::REQ_STEP);
  assign xs       = OW'($signed({1'b0, step_x_q}));
  assign ys       = OW'(step_y_q);
  assign can_step = active_q && (xs <= ys);
  assign x_ext    = DW'($signed({1'b0, step_x_q}));
  assign y_ext    = DW'(step_y_q);

  // Offsets of the eight symmetric points, in emit order
  always_comb begin
    off_x[0] = xs;  off_y[0] = ys;
    off_x[1] = -xs; off_y[1] = ys;
    off_x[2] = xs;  off_y[2] = -ys;
    off_x[3] = -xs; off_y[3] = -ys;
    off_x[4] = ys;  off_y[4] = xs;
    off_x[5] = -ys; off_y[5] = xs;
    off_x[6] = ys;  off_y[6] = -xs;
    off_x[7] = -ys; off_y[7] = -xs;
  end

  // A point equal to an earlier one of the same step is dropped
  always_comb begin
    for (int i = 0; i < cpg_pkg::NUM_PTS; i++) begin
      keep[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if ((off_x[j] == off_x[i]) && (off_y[j] == off_y[i])) begin
          keep[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    ctr_x_d  = ctr_x_q;
    ctr_y_d  = ctr_y_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    dec_d    = dec_q;
    active_d = active_q;
    if (accept_i && !is_step) begin
      ctr_x_d  = center_x_i;
      ctr_y_d  = center_y_i;
      step_x_d = '0;
      step_y_d = $signed({1'b0, radius_i});
      dec_d    = DW'(cpg_pkg::D_INIT) - (DW'(radius_i) <<< 1);
      active_d = 1'b1;
    end else if (accept_i && can_step) begin
      if (dec_q[DW-1]) begin
        dec_d = dec_q + (x_ext <<< 2) + DW'(cpg_pkg::D_ADD_NEG);
      end else begin
        dec_d    = dec_q + ((x_ext - y_ext) <<< 2) + DW'(cpg_pkg::D_ADD_POS);
        step_y_d = step_y_q - 1'b1;
      end
      step_x_d = step_x_q + 1'b1;
    end
  end

  // Completion check on the updated position
  assign xn = xs + OW'(1);
  assign yn = dec_q[DW-1] ? ys : ys - OW'(1);

  always_comb begin
    burst_ctl_o = '0;
    if (can_step) begin
      burst_ctl_o.mask     = keep;
      burst_ctl_o.pt_valid = 1'b1;
      burst_ctl_o.done     = (xn > yn);
    end else begin
      burst_ctl_o.mask     = cpg_pkg::NUM_PTS'(1);
      burst_ctl_o.pt_valid = 1'b0;
      burst_ctl_o.done     = 1'b1;
    end
  end

  assign burst_load_o = accept_i && is_step;
  assign ctr_x_o      = ctr_x_q;
  assign ctr_y_o      = ctr_y_q;
  assign pos_x_o      = step_x_q[RADIUS_BITS-1:0];
  assign pos_y_o      = step_y_q[RADIUS_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      ctr_x_q  <= ctr_x_d;
      ctr_y_q  <= ctr_y_d;
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

endmodule

/* rtl/core/cpg_emit.sv */
// ----------------------------------------------------------------------------
// cpg_emit
// Burst register and point sequencer: one point per cycle into the
// output register, while that register is empty or being read.
// ----------------------------------------------------------------------------
module cpg_emit #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  cpg_pkg::cpg_burst_t           ctl_i,
  input  logic signed [COORD_BITS-1:0]  ctr_x_i,
  input  logic signed [COORD_BITS-1:0]  ctr_y_i,
  input  logic        [RADIUS_BITS-1:0] pos_x_i,
  input  logic        [RADIUS_BITS-1:0] pos_y_i,
  input  logic                          out_ready_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic                          point_valid_o,
  output logic                          last_o,
  output logic                          done_o
);

  localparam int unsigned SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  // Burst register
  logic                          burst_v_q;
  cpg_pkg::cpg_burst_t           ctl_q;
  logic signed [COORD_BITS-1:0]  cx_q, cy_q;
  logic        [RADIUS_BITS-1:0] px_q, py_q;

  // Output register
  logic                          out_v_q;
  logic signed [COORD_BITS:0]    ox_q, oy_q;
  logic                          ov_q, ol_q, od_q;

  logic [2:0]                    idx;
  logic [cpg_pkg::NUM_PTS-1:0]   rest;
  logic                          take, last;
  logic        [RADIUS_BITS-1:0] a_sel, b_sel;
  logic signed [SW-1:0]          sum_x, sum_y;
  logic signed [COORD_BITS:0]    nx, ny;

  // Lowest pending point goes first
  always_comb begin
    idx = '0;
    for (int i = cpg_pkg::NUM_PTS - 1; i >= 0; i--) begin
      if (ctl_q.mask[i]) idx = 3'(i);
    end
  end

  assign rest = ctl_q.mask & ~(cpg_pkg::NUM_PTS'(1) << idx);
  assign last = (rest == '0);
  assign take = burst_v_q && (!out_v_q || out_ready_i);

  // Points 0-3 use (x, y), points 4-7 the swapped pair; bit 0 negates
  // the column offset, bit 1 the row offset.
  assign a_sel = idx[2] ? py_q : px_q;
  assign b_sel = idx[2] ? px_q : py_q;

  always_comb begin
    if (idx[0]) sum_x = SW'(cx_q) - SW'($signed({1'b0, a_sel}));
    else        sum_x = SW'(cx_q) + SW'($signed({1'b0, a_sel}));
    if (idx[1]) sum_y = SW'(cy_q) - SW'($signed({1'b0, b_sel}));
    else        sum_y = SW'(cy_q) + SW'($signed({1'b0, b_sel}));
    nx = ctl_q.pt_valid ? sum_x[COORD_BITS:0] : '0;
    ny = ctl_q.pt_valid ? sum_y[COORD_BITS:0] : '0;
  end

  assign free_o = !burst_v_q || (take && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_v_q <= 1'b0;
      ctl_q     <= '0;
    end else if (load_i) begin
      burst_v_q <= 1'b1;
      ctl_q     <= ctl_i;
    end else if (take) begin
      ctl_q.mask <= rest;
      if (last) burst_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cx_q <= ctr_x_i;
      cy_q <= ctr_y_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ox_q <= nx;
      oy_q <= ny;
      ov_q <= ctl_q.pt_valid;
      ol_q <= last;
      od_q <= last && ctl_q.done;
    end
  end

  assign out_valid_o   = out_v_q;
  assign point_x_o     = ox_q;
  assign point_y_o     = oy_q;
  assign point_valid_o = ov_q;
  assign last_o        = ol_q;
  assign done_o        = od_q;

endmodule

/* rtl/core/circle_point_generator.sv */
// ----------------------------------------------------------------------------
// circle_point_generator
// Midpoint circle rasterizer with stream input and output channels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_axis): tuser selects the request. A load item
//    (tuser 0) takes center and radius from tdata and produces no result.
//    A step item (tuser 1) runs one octant iteration.
//  - Output channel (m_axis): one item per distinct symmetric point of the
//    step, 1 to 8 items; tlast marks the final item of the step, tuser[1]
//    on that item flags the circle as complete. A step with no circle
//    loaded, or after completion, yields one item with tuser[0] low, zero
//    coordinates, tlast and done set.
//  - Path: the first point of a step moves from the burst register into
//    the output register, which drives m_axis.
//  - Burst: a step holds the burst register until all of its points
//    (1 to 8, 8 on a general octant) have moved on; the next item is taken
//    in the cycle its last point moves to the output register.
//  - Stall: a low m_axis_tready_i holds the output register and the burst;
//    s_axis_tready_o drops until the burst drains. Nothing is lost.
//  - Reset: no circle loaded, both channels empty.
// ----------------------------------------------------------------------------
module circle_point_generator #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [COORD_BITS-1:0] center_x, then center_y, then radius, zero padded
  input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // [0] req_type
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [COORD_BITS:0] point_x, then point_y, zero padded
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  // [0] point_valid, [1] done_res
  output logic [1:0]                m_axis_tuser_o,
  // last_of_step
  output logic                      m_axis_tlast_o
);

  localparam int unsigned IN_W  = ((2*COORD_BITS+RADIUS_BITS+7)/8)*8;
  localparam int unsigned OUT_W = ((2*COORD_BITS+2+7)/8)*8;
  localparam int unsigned PAD_W = OUT_W - 2*(COORD_BITS+1);

  logic                          accept;
  logic                          free;
  logic                          burst_load;
  cpg_pkg::cpg_burst_t           burst_ctl;
  logic signed [COORD_BITS-1:0]  ctr_x, ctr_y;
  logic        [RADIUS_BITS-1:0] pos_x, pos_y;
  logic signed [COORD_BITS:0]    point_x, point_y;
  logic                          point_valid, last_of_step, done_res;
  logic [IN_W-1:0]               in_data;

  assign in_data         = s_axis_tdata_i;
  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  // State and per-step mask; updates on the accepted item
  cpg_core #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (s_axis_tuser_i),
    .center_x_i   ($signed(in_data[COORD_BITS-1:0])),
    .center_y_i   ($signed(in_data[2*COORD_BITS-1:COORD_BITS])),
    .radius_i     (in_data[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .burst_load_o (burst_load),
    .burst_ctl_o  (burst_ctl),
    .ctr_x_o      (ctr_x),
    .ctr_y_o      (ctr_y),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y)
  );

  // Burst register feeding the output register one point per cycle while m_axis is not stalled
  cpg_emit #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (burst_load),
    .ctl_i         (burst_ctl),
    .ctr_x_i       (ctr_x),
    .ctr_y_i       (ctr_y),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .out_ready_i   (m_axis_tready_i),
    .free_o        (free),
    .out_valid_o   (m_axis_tvalid_o),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_valid_o (point_valid),
    .last_o        (last_of_step),
    .done_o        (done_res)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, point_y, point_x};
  assign m_axis_tuser_o = {done_res, point_valid};
  assign m_axis_tlast_o = last_of_step;

endmodule

/* rtl/core/cpg_checker.sv */
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level assertions for circle_point_generator, attached by bind.
// ----------------------------------------------------------------------------
module cpg_checker #(
  parameter int unsigned RADIUS_BITS = 14,
  parameter int unsigned COORD_BITS  = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input logic                      s_axis_tuser_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  input logic [1:0]                m_axis_tuser_o,
  input logic                      m_axis_tlast_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("cpg: stalled result changed");

  // Done only on the final item of a step
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o)
    else $error("cpg: done without last");

  // Invalid result is a lone, complete, zeroed item
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tlast_o && m_axis_tuser_o[1] && (m_axis_tdata_o == '0))
    else $error("cpg: malformed invalid result");

  // Input is not taken while a stalled item still has points queued behind it
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && !m_axis_tlast_o |->
      !(s_axis_tvalid_i && s_axis_tready_o))
    else $error("cpg: input taken mid-step");

  // Accepted input item carries known request and data
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |->
      !$isunknown({s_axis_tuser_i, s_axis_tdata_i}))
    else $error("cpg: unknown input item");

endmodule

bind circle_point_generator cpg_checker #(
  .RADIUS_BITS (RADIUS_BITS),
  .COORD_BITS  (COORD_BITS)
) u_cpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circle point generator. A behavioral
// rasterizer in the bench predicts the points of every step item. Each
// item on the output channel is checked in order against those points.
// Directed circles cover the corner cases, then random circles follow.
// Both channels stall at random, with one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RADIUS_BITS = 14;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned PT_BITS     = COORD_BITS + 1;
  localparam int unsigned IN_BYTES    = (2*COORD_BITS + RADIUS_BITS + 7) / 8;
  localparam int unsigned OUT_BYTES   = (2*PT_BITS + 7) / 8;

  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned SETTLE_CYC   = 12;    // end-of-run settle
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // One expected output item
  typedef struct {
    logic [PT_BITS-1:0] px;
    logic [PT_BITS-1:0] py;
    logic               valid;
    logic               last;
    logic               done;
  } circle_pt_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_BYTES*8-1:0]   s_axis_tdata_i = '0;
  logic                    s_axis_tuser_i = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_BYTES*8-1:0]  m_axis_tdata_o;
  logic [1:0]              m_axis_tuser_o;
  logic                    m_axis_tlast_o;

  // Points still owed by the DUT, oldest first
  circle_pt_t expected_pts[$];

  // Bench copy of the rasterizer state
  logic signed [COORD_BITS-1:0] ref_cx;
  logic signed [COORD_BITS-1:0] ref_cy;
  int                           oct_x;
  int                           oct_y;
  int                           decision;
  bit                           circle_loaded;

  // Full-rate stretch: neither side idles while set
  bit      full_rate = 1'b0;
  int      errors = 0;
  int      items_sent = 0;
  int      loads_sent = 0;
  int      steps_sent = 0;
  int      points_seen = 0;
  int      circles_closed = 0;
  longint  cycle_cnt = 0;

  always #4 clk_i = ~clk_i;

  circle_point_generator #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Circle finished: the next step only gives the invalid done item
  function automatic bit circle_complete();
    return circle_loaded && (oct_x > oct_y);
  endfunction

  // Predict one accepted item. A load only updates state; a step pushes
  // the distinct symmetric points of the current octant position.
  task automatic rasterize_item(input cpg_pkg::cpg_req_e kind,
                                input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [RADIUS_BITS-1:0] rad);
    int         cand_x [cpg_pkg::NUM_PTS];
    int         cand_y [cpg_pkg::NUM_PTS];
    bit         keep [cpg_pkg::NUM_PTS];
    int         a;
    int         b;
    int         last_idx;
    bit         fin;
    circle_pt_t pt;
    if (kind == cpg_pkg::REQ_LOAD) begin
      ref_cx = cx;
      ref_cy = cy;
      oct_x = 0;
      oct_y = int'(rad);
      decision = cpg_pkg::D_INIT - 2 * int'(rad);
      circle_loaded = 1'b1;
      return;
    end
    // no circle loaded, or circle already closed
    if (!circle_loaded || oct_x > oct_y) begin
      pt = '{px: '0, py: '0, valid: 1'b0, last: 1'b1, done: 1'b1};
      expected_pts.push_back(pt);
      return;
    end
    // order: (+x,+y) (-x,+y) (+x,-y) (-x,-y), then the same with x/y swapped
    for (int i = 0; i < cpg_pkg::NUM_PTS; i++) begin
      a = (i < 4) ? oct_x : oct_y;
      b = (i < 4) ? oct_y : oct_x;
      cand_x[i] = int'(ref_cx) + ((i % 2 == 1) ? -a : a);
      cand_y[i] = int'(ref_cy) + (((i / 2) % 2 == 1) ? -b : b);
      keep[i] = 1'b1;
      for (int j = 0; j < i; j++)
        if (cand_x[j] == cand_x[i] && cand_y[j] == cand_y[i]) keep[i] = 1'b0;
    end
    if (decision < 0) begin
      decision += 4 * oct_x + cpg_pkg::D_ADD_NEG;
    end else begin
      decision += 4 * (oct_x - oct_y) + cpg_pkg::D_ADD_POS;
      oct_y -= 1;
    end
    oct_x += 1;
    fin = oct_x > oct_y;
    last_idx = 0;
    for (int i = 0; i < cpg_pkg::NUM_PTS; i++)
      if (keep[i]) last_idx = i;
    for (int i = 0; i < cpg_pkg::NUM_PTS; i++) begin
      if (keep[i]) begin
        pt.px    = PT_BITS'(cand_x[i]);
        pt.py    = PT_BITS'(cand_y[i]);
        pt.valid = 1'b1;
        pt.last  = (i == last_idx);
        pt.done  = (i == last_idx) && fin;
        expected_pts.push_back(pt);
      end
    end
  endtask

  // Present one item and hold it until the DUT takes it. This task only
  // lowers tvalid in an idle gap, so back-to-back items keep it high.
  task automatic send_item(input cpg_pkg::cpg_req_e kind,
                           input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy,
                           input logic [RADIUS_BITS-1:0] rad);
    if (!full_rate && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    end
    rasterize_item(kind, cx, cy, rad);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {{(IN_BYTES*8 - 2*COORD_BITS - RADIUS_BITS){1'b0}}, rad, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (kind == cpg_pkg::REQ_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // Step fields are don't-care; fill them with noise
  task automatic send_step();
    send_item(cpg_pkg::REQ_STEP, 16'($urandom), 16'($urandom), 14'($urandom));
  endtask

  // Hold off the sender until every owed point has come out
  task automatic drain_points();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pts.size() != 0) @(posedge clk_i);
  endtask

  // Load a circle and step it until it closes or max_steps runs out
  task automatic trace_circle(input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy,
                              input logic [RADIUS_BITS-1:0] rad, input int max_steps);
    int n;
    n = 0;
    send_item(cpg_pkg::REQ_LOAD, cx, cy, rad);
    while (!circle_complete() && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  // Steps with nothing loaded since reset
  task automatic test_no_circle();
    send_step();
    send_step();
  endtask

  // Radius 0 collapses all eight points into one; then step past the end
  task automatic test_zero_radius();
    trace_circle(16'sd0, 16'sd0, 14'd0, 4);
    send_step();
  endtask

  // Small full circles: radius 1, and radius 3 which hits x == y
  task automatic test_small_circles();
    trace_circle(16'sd100, -16'sd100, 14'd1, 4);
    trace_circle(-16'sd5, 16'sd7, 14'd3, 8);
    send_step();
    drain_points();
  endtask

  // Center and radius extremes, left mid-circle by a reload
  task automatic test_extremes();
    trace_circle(16'h8000, 16'h7fff, 14'h3fff, 2);
    trace_circle(16'h7fff, 16'h8000, 14'h3fff, 2);
    trace_circle(16'hffff, 16'h0000, 14'h2aaa, 1);
    trace_circle(16'h5555, 16'haaaa, 14'h1555, 1);
  endtask

  // Random mix: mostly complete small circles, a few large radii cut
  // short, stray steps and abandoned circles. Middle third at full rate.
  task automatic test_random_circles();
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      full_rate = (items_sent - start >= RANDOM_ITEMS / 3) &&
                  (items_sent - start < 2 * RANDOM_ITEMS / 3);
      pick = $urandom_range(99);
      if (pick < 65) begin
        trace_circle(16'($urandom), 16'($urandom), 14'($urandom_range(0, 24)), 64);
        if ($urandom_range(99) < 30) send_step();
      end else if (pick < 78) begin
        trace_circle(16'($urandom), 16'($urandom), 14'($urandom), $urandom_range(1, 4));
      end else if (pick < 90) begin
        send_step();
      end else begin
        trace_circle(16'($urandom), 16'($urandom), 14'($urandom_range(0, 60)),
                     $urandom_range(0, 3));
      end
      if ($urandom_range(99) < 4) drain_points();
    end
    full_rate = 1'b0;
  endtask

  // Output side: random backpressure, cycle limit and in-order checking
  always @(posedge clk_i) begin
    circle_pt_t want;
    circle_pt_t got;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points still owed", $realtime, expected_pts.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      m_axis_tready_i <= full_rate || ($urandom_range(99) >= IDLE_PCT);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got.px    = m_axis_tdata_o[PT_BITS-1:0];
        got.py    = m_axis_tdata_o[2*PT_BITS-1:PT_BITS];
        got.valid = m_axis_tuser_o[0];
        got.done  = m_axis_tuser_o[1];
        got.last  = m_axis_tlast_o;
        points_seen++;
        if (got.done) circles_closed++;
        if (expected_pts.size() == 0) begin
          errors++;
          $display("%0t: unexpected item x=%0h y=%0h valid=%0b last=%0b done=%0b",
                   $realtime, got.px, got.py, got.valid, got.last, got.done);
        end else begin
          want = expected_pts.pop_front();
          if (got.px !== want.px) begin
            errors++;
            $display("%0t: point_x exp %0h got %0h", $realtime, want.px, got.px);
          end
          if (got.py !== want.py) begin
            errors++;
            $display("%0t: point_y exp %0h got %0h", $realtime, want.py, got.py);
          end
          if (got.valid !== want.valid) begin
            errors++;
            $display("%0t: point_valid exp %0b got %0b", $realtime, want.valid, got.valid);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last_of_step exp %0b got %0b", $realtime, want.last, got.last);
          end
          if (got.done !== want.done) begin
            errors++;
            $display("%0t: done_res exp %0b got %0b", $realtime, want.done, got.done);
          end
        end
      end
    end
  end

  initial begin
    circle_loaded = 1'b0;
    ref_cx = '0;
    ref_cy = '0;
    oct_x = 0;
    oct_y = 0;
    decision = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_circle();
    test_zero_radius();
    test_small_circles();
    test_extremes();
    test_random_circles();

    // let the last burst drain, then a short settle for stray items
    drain_points();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Covered %0d items (%0d loads, %0d steps), %0d points checked,",
             items_sent, loads_sent, steps_sent, points_seen);
    $display("%0d done flags, under random stalls on both channels", circles_closed);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
